### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is held
`define TSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen
`define TSR_ASSERT_NEVER(label, cond, msg) \
  `TSR_ASSERT(label, !(cond), msg)

`endif

### hw/rtl/tsr_pkg.sv
// types, constants and helpers for the servo ramp core
// no dependencies
`default_nettype none

package tsr_pkg;

  localparam int ANG_W     = 8;
  localparam int TIME_W    = 32;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int DVD_W     = TIME_W + ANG_W;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  // operation codes
  localparam logic [OP_W-1:0] OP_ANIMATE = 2'd0;
  localparam logic [OP_W-1:0] OP_RESET   = 2'd1;
  localparam logic [OP_W-1:0] OP_SETUP   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX = 2'd2;

  localparam logic [ANG_W-1:0] MIN_RST = 8'd0;
  localparam logic [ANG_W-1:0] MID_RST = 8'd90;
  localparam logic [ANG_W-1:0] MAX_RST = 8'd180;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_RES  = 4'b1000
  } tsr_state_t;

  typedef struct packed {
    logic accept;     // latch the input item
    logic mul_start;  // multiply and start the divider
    logic commit;     // update ramp state and load the result register
  } tsr_cmd_t;

  typedef struct packed {
    logic slow;       // incoming item needs the multiply/divide path
    logic div_done;   // last divider iteration this cycle
  } tsr_sts_t;

  function automatic logic [ANG_W-1:0] limit_clamp(input logic [ANG_W-1:0] p,
                                                   input logic [ANG_W-1:0] mn,
                                                   input logic [ANG_W-1:0] mx);
    logic [ANG_W-1:0] r;
    r = p;
    if (mx > mn) begin
      if (p > mx) r = mx;
    end else begin
      if (p < mn) r = mn;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tsr_div.sv
// restoring divider, one quotient bit per cycle
// depends on tsr_pkg
`default_nettype none

module tsr_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [tsr_pkg::DVD_W-1:0]  dividend,
  input  wire logic [tsr_pkg::TIME_W-1:0] divisor,
  output logic                            done,
  output logic [tsr_pkg::DVD_W-1:0]       quotient
);
  import tsr_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [TIME_W-1:0]    rem_r, rem_nxt;
  logic [TIME_W-1:0]    dsr_r, dsr_nxt;
  logic [TIME_W:0]      rem_sh;
  logic [TIME_W:0]      rem_sub;
  logic                 ge;
  logic                 last;

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign ge      = (rem_sh >= {1'b0, dsr_r});
  assign last    = busy_r && (cnt_r == DIV_CNT_W'(DVD_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      rem_nxt = ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (last) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = last;
  assign quotient = dvd_r;

endmodule

`default_nettype wire

### hw/rtl/tsr_ctrl.sv
// controller state machine for the servo ramp core
// depends on tsr_pkg
`default_nettype none

module tsr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire tsr_pkg::tsr_sts_t sts,
  output tsr_pkg::tsr_cmd_t      cmd
);
  import tsr_pkg::*;

  tsr_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.accept    = in_valid && (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = sts.slow ? ST_MUL : ST_RES;
      end
      ST_MUL: begin
        cmd.mul_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_RES;
      end
      ST_RES: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### hw/rtl/tsr_dpath.sv
// datapath of the servo ramp core: limits, ramp state, multiply, divide, result register
// depends on tsr_pkg and tsr_div
`default_nettype none

module tsr_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tsr_pkg::tsr_cmd_t             cmd,
  output tsr_pkg::tsr_sts_t                  sts,
  input  wire logic [tsr_pkg::OP_W-1:0]      in_operation,
  input  wire logic [tsr_pkg::TIME_W-1:0]    in_now_ms,
  input  wire logic [tsr_pkg::ANG_W-1:0]     in_target_angle,
  input  wire logic [tsr_pkg::TIME_W-1:0]    in_ramp_duration,
  input  wire logic                          cfg_we,
  input  wire logic [tsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tsr_pkg::ANG_W-1:0]     cfg_wdata,
  output logic [tsr_pkg::ANG_W-1:0]          out_position,
  output logic                               out_position_valid,
  output logic                               out_finished
);
  import tsr_pkg::*;

  // limit registers
  logic [ANG_W-1:0]  min_r, mid_r, max_r;

  // latched item
  logic [OP_W-1:0]   op_r;
  logic [TIME_W-1:0] now_r, dur_r;
  logic [ANG_W-1:0]  tgt_r;

  // ramp state
  logic              done_r, done_nxt;
  logic              started_r, started_nxt;
  logic [TIME_W-1:0] stime_r, stime_nxt;
  logic [ANG_W-1:0]  sang_r, sang_nxt;

  // result register
  logic [ANG_W-1:0]  pos_r, pos_nxt;
  logic              pval_r, pval_nxt;
  logic              fin_r, fin_nxt;

  logic [TIME_W-1:0] elapsed;
  logic              up;
  logic [ANG_W-1:0]  absdiff;
  logic [DVD_W-1:0]  product;
  logic [DVD_W-1:0]  quot;
  logic              div_done;
  logic              reached;
  logic [ANG_W-1:0]  angle;
  logic              jump;

  // path choice for the item being offered
  assign sts.slow = (in_operation == OP_ANIMATE) && !done_r && (in_ramp_duration != '0)
                    && (sang_r != in_target_angle);
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_RST;
      mid_r <= MID_RST;
      max_r <= MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN: min_r <= cfg_wdata;
        CFG_MID: mid_r <= cfg_wdata;
        CFG_MAX: max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_operation;
      now_r <= in_now_ms;
      tgt_r <= in_target_angle;
      dur_r <= in_ramp_duration;
    end
  end

  // first ramp step sees zero elapsed time
  assign elapsed = started_r ? (now_r - stime_r) : '0;
  assign up      = (tgt_r > sang_r);
  assign absdiff = up ? (tgt_r - sang_r) : (sang_r - tgt_r);
  assign product = DVD_W'(elapsed) * DVD_W'(absdiff);

  tsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mul_start),
    .dividend (product),
    .divisor  (dur_r),
    .done     (div_done),
    .quotient (quot)
  );

  assign reached = (quot >= DVD_W'(absdiff));
  assign angle   = reached ? tgt_r : (up ? (sang_r + quot[ANG_W-1:0])
                                         : (sang_r - quot[ANG_W-1:0]));
  assign jump    = (dur_r == '0) || (sang_r == tgt_r);

  always_comb begin
    done_nxt    = done_r;
    started_nxt = started_r;
    stime_nxt   = stime_r;
    sang_nxt    = sang_r;
    pos_nxt     = pos_r;
    pval_nxt    = pval_r;
    fin_nxt     = fin_r;
    if (cmd.mul_start && !started_r) begin
      started_nxt = 1'b1;
      stime_nxt   = now_r;
    end
    if (cmd.commit) begin
      pos_nxt  = '0;
      pval_nxt = 1'b0;
      case (op_r)
        OP_ANIMATE: begin
          if (!done_r) begin
            pval_nxt = 1'b1;
            if (jump) begin
              pos_nxt  = limit_clamp(tgt_r, min_r, max_r);
              done_nxt = 1'b1;
            end else begin
              pos_nxt = limit_clamp(angle, min_r, max_r);
              if (reached) begin
                sang_nxt = tgt_r;
                done_nxt = 1'b1;
              end
            end
          end
        end
        OP_RESET: begin
          done_nxt    = 1'b0;
          started_nxt = 1'b0;
          stime_nxt   = '0;
        end
        OP_SETUP: begin
          done_nxt    = 1'b0;
          started_nxt = 1'b0;
          stime_nxt   = '0;
          pos_nxt     = limit_clamp(mid_r, min_r, max_r);
          pval_nxt    = 1'b1;
        end
        default: ;
      endcase
      fin_nxt = done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r    <= 1'b0;
      started_r <= 1'b0;
      stime_r   <= '0;
      sang_r    <= '0;
    end else begin
      done_r    <= done_nxt;
      started_r <= started_nxt;
      stime_r   <= stime_nxt;
      sang_r    <= sang_nxt;
    end
    pos_r  <= pos_nxt;
    pval_r <= pval_nxt;
    fin_r  <= fin_nxt;
  end

  assign out_position       = pos_r;
  assign out_position_valid = pval_r;
  assign out_finished       = fin_r;

endmodule

`default_nettype wire

### hw/rtl/timed_servo_ramp_core.sv
// top level of the servo position ramp core
// depends on tsr_pkg, tsr_ctrl, tsr_dpath (with tsr_div) and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// Servo position ramp generator. Each input transfer carries an operation
// (animate step, reset animation, setup), the current millisecond time, a
// target angle and a ramp duration, and yields exactly one result transfer:
// the position written (zero when none), a position-written flag and the
// finished flag. An animate step on a running ramp is taken, then passes
// through the 32x8 multiply of elapsed time by the angle span, the bit-serial
// restoring divider (one quotient bit per cycle of a 40-bit dividend) and the
// step that updates state and loads the result register. Every other item
// (jump to target, ramp already done, reset, setup, unused code) goes from
// being taken straight to that last step. The result register holds the
// result until the transfer on the out_ side, so a new input is taken while
// a result still waits; a further result waits only if the previous one has
// not left. Limit registers are written through cfg_we/cfg_index/cfg_wdata
// (index 0 min, 1 mid, 2 max, index 3 ignored) and should be changed only
// while the core is idle.
module timed_servo_ramp_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tsr_pkg::OP_W-1:0]      in_operation,
  input  wire logic [tsr_pkg::TIME_W-1:0]    in_now_ms,
  input  wire logic [tsr_pkg::ANG_W-1:0]     in_target_angle,
  input  wire logic [tsr_pkg::TIME_W-1:0]    in_ramp_duration,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tsr_pkg::ANG_W-1:0]          out_position,
  output logic                               out_position_valid,
  output logic                               out_finished,
  // limit register writes
  input  wire logic                          cfg_we,
  input  wire logic [tsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tsr_pkg::ANG_W-1:0]     cfg_wdata
);
  import tsr_pkg::*;

  tsr_cmd_t cmd;
  tsr_sts_t sts;

  // sequencing: idle, multiply, divide, write result
  tsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // limits, ramp state, arithmetic and the result register
  tsr_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_operation),
    .in_now_ms          (in_now_ms),
    .in_target_angle    (in_target_angle),
    .in_ramp_duration   (in_ramp_duration),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_position       (out_position),
    .out_position_valid (out_position_valid),
    .out_finished       (out_finished)
  );

  // one item in flight: no second transfer straight after the first
  `TSR_ASSERT(a_one_in_flight, (in_valid && in_ready) |=> !in_ready, "second item taken while busy")

  // a fresh result only appears once an item has been taken and worked on
  `TSR_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(!in_ready), "result without work")

  // no stray position when nothing was written
  `TSR_ASSERT_NEVER(a_no_stray_pos, out_valid && !out_position_valid && (out_position != '0), "position set but not written")

endmodule

`default_nettype wire
